// ----- design/atan2_angle_index_macros.svh -----
// ---------------------------------------------------------------------------
// atan2_angle_index assertion macros
// Concurrent check wrappers; they expand to nothing for synthesis.
// ---------------------------------------------------------------------------
`ifndef ATAN2_ANGLE_INDEX_MACROS_SVH
`define ATAN2_ANGLE_INDEX_MACROS_SVH

`ifndef SYNTHESIS
// Check that prop holds at every clock edge outside reset.
`define A2AI_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed in %m");
// Check that cons holds in the cycle after ante.
`define A2AI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed in %m");
`else
`define A2AI_ASSERT(lbl, clk, rstn, prop)
`define A2AI_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- design/a2ai_pkg.sv -----
// ---------------------------------------------------------------------------
// a2ai_pkg
// Shared widths, angle constants and stage payload types.
// ---------------------------------------------------------------------------
package a2ai_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned MAG_W   = COORD_W - 1;
  localparam int unsigned ANGLE_W = 16;
  // Quotient bits down to the rounding bit of the 12-bit fraction
  localparam int unsigned QUO_W   = 13;
  localparam int unsigned DIV_STAGES = QUO_W;
  // Drop the rounding bit and the five fraction bits below the index
  localparam int unsigned IDX_SHIFT = 6;
  localparam int unsigned ROM_DEPTH = 129;
  localparam int unsigned IDX_W     = 8;

  localparam logic [ANGLE_W-1:0] ANGLE_EIGHTH  = 16'h2000;
  localparam logic [ANGLE_W-1:0] ANGLE_QUARTER = 16'h4000;
  localparam logic [ANGLE_W-1:0] ANGLE_HALF    = 16'h8000;
  localparam logic [ANGLE_W-1:0] ANGLE_3QUART  = 16'hC000;

  // How the final stage forms the angle from the base
  typedef enum logic [1:0] {
    MODE_DIRECT,
    MODE_ADD,
    MODE_SUB
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [ANGLE_W-1:0] base;
  } ctrl_t;

  typedef struct packed {
    ctrl_t            ctrl;
    logic [MAG_W-1:0] rem;
    logic [MAG_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } div_t;

endpackage

// ----- design/a2ai_fold.sv -----
// ---------------------------------------------------------------------------
// a2ai_fold
// Octant folding: magnitudes, special angles and divider operands.
// ---------------------------------------------------------------------------
`include "atan2_angle_index_macros.svh"

module a2ai_fold (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [a2ai_pkg::COORD_W-1:0] y_coord_i,
  input  logic signed [a2ai_pkg::COORD_W-1:0] x_coord_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output a2ai_pkg::div_t                     out_data_o
);

  function automatic logic [a2ai_pkg::MAG_W-1:0] sat_mag(
    input logic [a2ai_pkg::COORD_W-1:0] v
  );
    logic [a2ai_pkg::COORD_W-1:0] neg;
    neg = ~v + 1'b1;
    if (!v[a2ai_pkg::COORD_W-1]) begin
      return v[a2ai_pkg::MAG_W-1:0];
    end else if (v[a2ai_pkg::MAG_W-1:0] == '0) begin
      return '1;
    end else begin
      return neg[a2ai_pkg::MAG_W-1:0];
    end
  endfunction

  logic                         yn, xn, odd;
  logic [a2ai_pkg::MAG_W-1:0]   ym, xm, along, across;
  logic [a2ai_pkg::ANGLE_W-1:0] quad_base;
  a2ai_pkg::div_t               data_d, data_q;
  logic                         valid_q;

  assign yn  = y_coord_i[a2ai_pkg::COORD_W-1];
  assign xn  = x_coord_i[a2ai_pkg::COORD_W-1];
  assign ym  = sat_mag(y_coord_i);
  assign xm  = sat_mag(x_coord_i);
  assign odd = yn ^ xn;
  assign along  = odd ? ym : xm;
  assign across = odd ? xm : ym;

  always_comb begin
    case ({yn, xn})
      2'b00:   quad_base = '0;
      2'b01:   quad_base = a2ai_pkg::ANGLE_QUARTER;
      2'b11:   quad_base = a2ai_pkg::ANGLE_HALF;
      default: quad_base = a2ai_pkg::ANGLE_3QUART;
    endcase
  end

  always_comb begin
    data_d           = '0;
    data_d.ctrl.mode = a2ai_pkg::MODE_DIRECT;
    if (ym == '0) begin
      data_d.ctrl.base = (xn && xm != '0) ? a2ai_pkg::ANGLE_HALF : '0;
    end else if (xm == '0) begin
      data_d.ctrl.base = yn ? a2ai_pkg::ANGLE_3QUART : a2ai_pkg::ANGLE_QUARTER;
    end else if (xm == ym) begin
      data_d.ctrl.base = quad_base + a2ai_pkg::ANGLE_EIGHTH;
    end else if (along > across) begin
      data_d.ctrl.mode = a2ai_pkg::MODE_ADD;
      data_d.ctrl.base = quad_base;
      data_d.rem       = across;
      data_d.den       = along;
    end else begin
      // measure back from the far axis of the quadrant
      data_d.ctrl.mode = a2ai_pkg::MODE_SUB;
      data_d.ctrl.base = quad_base + a2ai_pkg::ANGLE_QUARTER;
      data_d.rem       = along;
      data_d.den       = across;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  `A2AI_ASSERT(a_fold_operands, clk_i, rst_ni,
    !valid_q || data_q.ctrl.mode == a2ai_pkg::MODE_DIRECT ||
    (data_q.rem != '0 && data_q.rem < data_q.den))

endmodule

// ----- design/a2ai_div_stage.sv -----
// ---------------------------------------------------------------------------
// a2ai_div_stage
// One restoring division step: one quotient bit per stage.
// ---------------------------------------------------------------------------
`include "atan2_angle_index_macros.svh"

module a2ai_div_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  a2ai_pkg::div_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output a2ai_pkg::div_t out_data_o
);

  logic [a2ai_pkg::MAG_W:0] rem2, den_ext, diff;
  logic                     take;
  a2ai_pkg::div_t           data_d, data_q;
  logic                     valid_q;

  assign rem2    = {in_data_i.rem, 1'b0};
  assign den_ext = {1'b0, in_data_i.den};
  assign take    = rem2 >= den_ext;
  assign diff    = rem2 - den_ext;

  always_comb begin
    data_d     = in_data_i;
    data_d.rem = take ? diff[a2ai_pkg::MAG_W-1:0] : rem2[a2ai_pkg::MAG_W-1:0];
    data_d.quo = {in_data_i.quo[a2ai_pkg::QUO_W-2:0], take};
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  `A2AI_ASSERT(a_div_rem_below_den, clk_i, rst_ni,
    !valid_q || data_q.ctrl.mode == a2ai_pkg::MODE_DIRECT || data_q.rem < data_q.den)

endmodule

// ----- design/a2ai_lookup.sv -----
// ---------------------------------------------------------------------------
// a2ai_lookup
// Round the quotient, read the arctangent table, apply the octant base.
// ---------------------------------------------------------------------------
`include "atan2_angle_index_macros.svh"

module a2ai_lookup (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  a2ai_pkg::div_t               in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [a2ai_pkg::ANGLE_W-1:0] out_angle_o
);

  // entry k is atan(k/128) in angle units
  localparam logic [a2ai_pkg::ANGLE_W-1:0] ATAN_ROM [a2ai_pkg::ROM_DEPTH] = '{
    16'h0000, 16'h0051, 16'h00a3, 16'h00f4, 16'h0146, 16'h0197, 16'h01e9, 16'h023a,
    16'h028b, 16'h02dc, 16'h032d, 16'h037e, 16'h03cf, 16'h0420, 16'h0470, 16'h04c1,
    16'h0511, 16'h0561, 16'h05b1, 16'h0601, 16'h0651, 16'h06a0, 16'h06ef, 16'h073e,
    16'h078d, 16'h07dc, 16'h082a, 16'h0878, 16'h08c6, 16'h0914, 16'h0961, 16'h09ae,
    16'h09fb, 16'h0a48, 16'h0a94, 16'h0ae0, 16'h0b2c, 16'h0b77, 16'h0bc2, 16'h0c0d,
    16'h0c57, 16'h0ca1, 16'h0ceb, 16'h0d34, 16'h0d7d, 16'h0dc6, 16'h0e0f, 16'h0e56,
    16'h0e9e, 16'h0ee5, 16'h0f2c, 16'h0f73, 16'h0fb9, 16'h0fff, 16'h1044, 16'h1089,
    16'h10ce, 16'h1112, 16'h1156, 16'h1199, 16'h11dc, 16'h121f, 16'h1261, 16'h12a3,
    16'h12e4, 16'h1325, 16'h1366, 16'h13a6, 16'h13e6, 16'h1425, 16'h1464, 16'h14a2,
    16'h14e0, 16'h151e, 16'h155b, 16'h1598, 16'h15d5, 16'h1611, 16'h164c, 16'h1688,
    16'h16c2, 16'h16fd, 16'h1737, 16'h1770, 16'h17aa, 16'h17e2, 16'h181b, 16'h1853,
    16'h188a, 16'h18c1, 16'h18f8, 16'h192e, 16'h1964, 16'h199a, 16'h19cf, 16'h1a04,
    16'h1a38, 16'h1a6c, 16'h1a9f, 16'h1ad3, 16'h1b05, 16'h1b38, 16'h1b6a, 16'h1b9c,
    16'h1bcd, 16'h1bfe, 16'h1c2e, 16'h1c5e, 16'h1c8e, 16'h1cbe, 16'h1ced, 16'h1d1b,
    16'h1d4a, 16'h1d78, 16'h1da5, 16'h1dd3, 16'h1dff, 16'h1e2c, 16'h1e58, 16'h1e84,
    16'h1eb0, 16'h1edb, 16'h1f06, 16'h1f30, 16'h1f5a, 16'h1f84, 16'h1fae, 16'h1fd7,
    16'h2000
  };

  localparam logic [a2ai_pkg::IDX_W-1:0] IDX_MAX = a2ai_pkg::IDX_W'(a2ai_pkg::ROM_DEPTH - 1);

  logic [a2ai_pkg::QUO_W:0]     quo_rnd;
  logic [a2ai_pkg::IDX_W-1:0]   idx_raw, idx;
  logic [a2ai_pkg::ANGLE_W-1:0] rom_val, angle_d, angle_q;
  logic                         valid_q;

  // half-up rounding then drop to the table index
  assign quo_rnd = {1'b0, in_data_i.quo} + 1'b1;
  assign idx_raw = quo_rnd[a2ai_pkg::QUO_W:a2ai_pkg::IDX_SHIFT];
  assign idx     = (idx_raw > IDX_MAX) ? IDX_MAX : idx_raw;
  assign rom_val = ATAN_ROM[idx];

  always_comb begin
    case (in_data_i.ctrl.mode)
      a2ai_pkg::MODE_ADD: angle_d = in_data_i.ctrl.base + rom_val;
      a2ai_pkg::MODE_SUB: angle_d = in_data_i.ctrl.base - rom_val;
      default:            angle_d = in_data_i.ctrl.base;
    endcase
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      angle_q <= angle_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_angle_o = angle_q;

  `A2AI_ASSERT_NEXT(a_lookup_loads, clk_i, rst_ni, in_valid_i && in_ready_o, valid_q)

endmodule

// ----- design/atan2_angle_index.sv -----
// ---------------------------------------------------------------------------
// atan2_angle_index
// Four-quadrant arctangent of a 20.12 pair as a 16-bit angle index.
// ---------------------------------------------------------------------------
//
//  Channel  Dir  Width  Contents
//  s_axis   in   64     y_coord [31:0], x_coord [63:32], both signed
//  m_axis   out  16     angle_index [15:0], 65536 is one full turn
//
//  From input transfer to result a pair passes one folding stage,
//  thirteen divider stages (one quotient bit each) and one table stage.
//  A new pair is taken every cycle unless an output stall has filled the
//  folding stage; the 32-bit compare-subtract of a divider stage sets the
//  clock period. Reset empties every stage; no payload register is cleared.
//  Each stage holds its item while the next one is full and stalled, so an
//  empty stage upstream still takes a transfer during an output stall.
// ---------------------------------------------------------------------------
module atan2_angle_index (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input pairs
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] y_coord, [63:32] x_coord
  // Result angles
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [15:0] angle_index
);

  // Handshake chain through the divider: index 0 is the folding stage output,
  // index k+1 the output of divider stage g_div[k].
  logic [a2ai_pkg::DIV_STAGES:0] stg_valid;
  logic [a2ai_pkg::DIV_STAGES:0] stg_ready;
  a2ai_pkg::div_t                stg_data [a2ai_pkg::DIV_STAGES+1];

  logic signed [a2ai_pkg::COORD_W-1:0] y_coord, x_coord;

  // Unpack the transfer: y in the low half, x in the high half
  assign y_coord = s_axis_tdata_i[a2ai_pkg::COORD_W-1:0];
  assign x_coord = s_axis_tdata_i[2*a2ai_pkg::COORD_W-1:a2ai_pkg::COORD_W];

  // Fold into an octant, settle the axes and diagonals
  a2ai_fold u_fold (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .y_coord_i   (y_coord),
    .x_coord_i   (x_coord),
    .out_valid_o (stg_valid[0]),
    .out_ready_i (stg_ready[0]),
    .out_data_o  (stg_data[0])
  );

  // Divide the smaller magnitude by the larger, one quotient bit per stage
  for (genvar k = 0; k < a2ai_pkg::DIV_STAGES; k++) begin : g_div
    a2ai_div_stage u_div (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stg_valid[k]),
      .in_ready_o  (stg_ready[k]),
      .in_data_i   (stg_data[k]),
      .out_valid_o (stg_valid[k+1]),
      .out_ready_i (stg_ready[k+1]),
      .out_data_o  (stg_data[k+1])
    );
  end

  // Round, read the table and apply the octant base; this stage is the
  // output register
  a2ai_lookup u_lookup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stg_valid[a2ai_pkg::DIV_STAGES]),
    .in_ready_o  (stg_ready[a2ai_pkg::DIV_STAGES]),
    .in_data_i   (stg_data[a2ai_pkg::DIV_STAGES]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_angle_o (m_axis_tdata_o)
  );

endmodule
